// File: rtl/bcte_pkg.sv
// Shared types, codes and field widths of the block chain table engine.
package bcte_pkg;

    localparam int OP_W       = 3;
    localparam int BLOCK_W    = 16;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 16;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd2;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_OFFSET   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BLOCK_COUNT = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC     = 3'd0,
        OP_APPEND    = 3'd1,
        OP_FREE      = 3'd2,
        OP_FIND_LAST = 3'd3,
        OP_READ      = 3'd4,
        OP_WRITE     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_FREE = 2'd1,
        STATUS_CORRUPT = 2'd2,
        STATUS_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BLOCK_W-1:0] block;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } bcte_req_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]  block_out;
        logic [STATUS_W-1:0] status;
    } bcte_rsp_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_IDX,
        PTR_BLK,
        PTR_INC,
        PTR_ENT
    } ptr_sel_t;

    typedef enum logic {
        WA_PTR,
        WA_TGT
    } wr_addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_ONE,
        WD_VAL,
        WD_ABS
    } wr_data_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ABS,
        RES_ENT
    } res_sel_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_LINK,
        S_WALK,
        S_READ,
        S_WRITE,
        S_DONE
    } ctl_state_t;

    typedef struct packed {
        logic         load_req;
        ptr_sel_t     ptr_sel;
        logic         steps_clr;
        logic         steps_inc;
        logic         tgt_load;
        logic         wr_en;
        wr_addr_sel_t wr_addr_sel;
        wr_data_sel_t wr_data_sel;
        logic         fin_load;
        res_sel_t     fin_res_sel;
        status_t      fin_status;
        logic         out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic blk_ok;
        logic idx_ok;
        logic ptr_end;
        logic ptr_last;
        logic ent_zero;
        logic ent_one;
        logic ent_maps;
        logic steps_limit;
    } dp_stat_t;

endpackage

// File: rtl/bcte_if.sv
// Request and response channel interfaces.
interface bcte_req_if
    import bcte_pkg::*;
;
    logic      valid;
    logic      ready;
    bcte_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bcte_rsp_if
    import bcte_pkg::*;
;
    logic      valid;
    logic      ready;
    bcte_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/bcte_ctrl.sv
// Sequencer for the chain table operations.
module bcte_ctrl
    import bcte_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [OP_W-1:0]     req_op,
    output logic                req_ready,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output dp_cmd_t             cmd,
    input  dp_stat_t            stat
);

    ctl_state_t state_reg, state_next;
    op_t        op_reg, op_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= OP_ALLOC;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        req_ready  = 1'b0;
        cmd        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_PTR;
                cmd.wr_data_sel = WD_ZERO;
                if (stat.ptr_last)
                begin
                    cmd.ptr_sel = PTR_ZERO;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.ptr_sel = PTR_INC;
                end
            end

            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    op_next      = op_t'(req_op);
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        cmd.ptr_sel = PTR_IDX;
                        state_next  = S_SCAN;
                    end
                    OP_APPEND:
                    begin
                        if (!stat.blk_ok)
                        begin
                            cmd.fin_load   = 1'b1;
                            cmd.fin_status = STATUS_RANGE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.tgt_load = 1'b1;
                            cmd.ptr_sel  = PTR_IDX;
                            state_next   = S_SCAN;
                        end
                    end
                    OP_FREE, OP_FIND_LAST:
                    begin
                        if (!stat.blk_ok)
                        begin
                            cmd.fin_load   = 1'b1;
                            cmd.fin_status = STATUS_RANGE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_sel   = PTR_BLK;
                            cmd.steps_clr = 1'b1;
                            state_next    = S_WALK;
                        end
                    end
                    OP_READ, OP_WRITE:
                    begin
                        if (!stat.idx_ok)
                        begin
                            cmd.fin_load   = 1'b1;
                            cmd.fin_status = STATUS_RANGE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.ptr_sel = PTR_IDX;
                            state_next  = (op_reg == OP_READ) ? S_READ : S_WRITE;
                        end
                    end
                    default:
                    begin
                        // unused op codes: no table change, zero result
                        cmd.fin_load   = 1'b1;
                        cmd.fin_status = STATUS_OK;
                        state_next     = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (stat.ptr_end)
                begin
                    cmd.fin_load   = 1'b1;
                    cmd.fin_status = STATUS_NO_FREE;
                    state_next     = S_DONE;
                end
                else if (stat.ent_zero)
                begin
                    cmd.wr_en = 1'b1;
                    if (op_reg == OP_APPEND)
                    begin
                        // link old end first so a free given block still ends as 1
                        cmd.wr_addr_sel = WA_TGT;
                        cmd.wr_data_sel = WD_ABS;
                        state_next      = S_LINK;
                    end
                    else
                    begin
                        cmd.wr_addr_sel = WA_PTR;
                        cmd.wr_data_sel = WD_ONE;
                        cmd.fin_load    = 1'b1;
                        cmd.fin_res_sel = RES_ABS;
                        cmd.fin_status  = STATUS_OK;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    cmd.ptr_sel = PTR_INC;
                end
            end

            S_LINK:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_PTR;
                cmd.wr_data_sel = WD_ONE;
                cmd.fin_load    = 1'b1;
                cmd.fin_res_sel = RES_ABS;
                cmd.fin_status  = STATUS_OK;
                state_next      = S_DONE;
            end

            S_WALK:
            begin
                if (stat.ent_one)
                begin
                    cmd.wr_en       = (op_reg == OP_FREE);
                    cmd.wr_addr_sel = WA_PTR;
                    cmd.wr_data_sel = WD_ZERO;
                    cmd.fin_load    = 1'b1;
                    cmd.fin_res_sel = (op_reg == OP_FIND_LAST) ? RES_ABS : RES_ZERO;
                    cmd.fin_status  = STATUS_OK;
                    state_next      = S_DONE;
                end
                else if (stat.ent_zero || !stat.ent_maps || stat.steps_limit)
                begin
                    cmd.fin_load   = 1'b1;
                    cmd.fin_status = STATUS_CORRUPT;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.wr_en       = (op_reg == OP_FREE);
                    cmd.wr_addr_sel = WA_PTR;
                    cmd.wr_data_sel = WD_ZERO;
                    cmd.steps_inc   = 1'b1;
                    cmd.ptr_sel     = PTR_ENT;
                end
            end

            S_READ:
            begin
                cmd.fin_load    = 1'b1;
                cmd.fin_res_sel = RES_ENT;
                cmd.fin_status  = STATUS_OK;
                state_next      = S_DONE;
            end

            S_WRITE:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_PTR;
                cmd.wr_data_sel = WD_VAL;
                cmd.fin_load    = 1'b1;
                cmd.fin_status  = STATUS_OK;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/bcte_dpath.sv
// Chain table memory, pointers, range checks and result registers.
module bcte_dpath
    import bcte_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  bcte_req_t             req_payload,
    output bcte_rsp_t             rsp_payload,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = IW + 1;
    localparam int PW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [PW-1:0] DEPTH_PW = PW'(TABLE_DEPTH);
    localparam logic [PW-1:0] LAST_PW  = PW'(TABLE_DEPTH - 1);

    logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];

    logic [OFFSET_W-1:0]    offset_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [PW-1:0]          ptr_reg, ptr_next;
    logic [PW-1:0]          steps_reg, steps_next;
    logic [IW-1:0]          tgt_reg;
    logic [BLOCK_W-1:0]     blk_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [VALUE_W-1:0]     val_reg;
    logic [ENTRY_WIDTH-1:0] rd_data_reg;
    logic [BLOCK_W-1:0]     fin_res_reg;
    status_t                fin_status_reg;
    logic [BLOCK_W-1:0]     out_block_reg;
    status_t                out_status_reg;

    logic [31:0]            count_w;
    logic [PW-1:0]          n_used;
    logic [32:0]            blk_diff;
    logic [32:0]            ent_diff;
    logic [32:0]            abs_sum;
    logic [ENTRY_WIDTH-1:0] abs_ent;
    logic [PW-1:0]          blk_idx;
    logic [PW-1:0]          ent_idx;
    logic [PW:0]            steps_inc_w;
    logic [IW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic [BLOCK_W-1:0]     fin_res;

    // entries in use: the smaller of the register and the table depth
    assign count_w = 32'(count_reg);
    assign n_used  = (count_w < 32'(TABLE_DEPTH)) ? PW'(count_reg) : DEPTH_PW;

    assign blk_diff = 33'(blk_reg) - 33'(offset_reg);
    assign ent_diff = 33'(rd_data_reg) - 33'(offset_reg);
    assign blk_idx  = blk_diff[PW-1:0];
    assign ent_idx  = ent_diff[PW-1:0];

    assign abs_sum = 33'(offset_reg) + 33'(ptr_reg);
    assign abs_ent = abs_sum[ENTRY_WIDTH-1:0];

    assign steps_inc_w = {1'b0, steps_reg} + {{PW{1'b0}}, 1'b1};

    assign stat.blk_ok      = !blk_diff[32] && (blk_diff[31:0] < 32'(n_used));
    assign stat.idx_ok      = PW'(idx_reg) < n_used;
    assign stat.ptr_end     = ptr_reg >= n_used;
    assign stat.ptr_last    = ptr_reg == LAST_PW;
    assign stat.ent_zero    = rd_data_reg == '0;
    assign stat.ent_one     = rd_data_reg == ENTRY_WIDTH'(1);
    assign stat.ent_maps    = !ent_diff[32] && (ent_diff[31:0] < 32'(n_used));
    assign stat.steps_limit = steps_inc_w >= {1'b0, n_used};

    always_comb
    begin
        case (cmd.ptr_sel)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_ZERO: ptr_next = '0;
            PTR_IDX:  ptr_next = PW'(idx_reg);
            PTR_BLK:  ptr_next = blk_idx;
            PTR_INC:  ptr_next = ptr_reg + PW'(1);
            PTR_ENT:  ptr_next = ent_idx;
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.steps_clr)
            steps_next = '0;
        else if (cmd.steps_inc)
            steps_next = steps_inc_w[PW-1:0];
        else
            steps_next = steps_reg;
    end

    assign wr_addr = (cmd.wr_addr_sel == WA_TGT) ? tgt_reg : ptr_reg[IW-1:0];

    always_comb
    begin
        case (cmd.wr_data_sel)
            WD_ZERO: wr_data = '0;
            WD_ONE:  wr_data = ENTRY_WIDTH'(1);
            WD_VAL:  wr_data = ENTRY_WIDTH'(val_reg);
            WD_ABS:  wr_data = abs_ent;
            default: wr_data = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.fin_res_sel)
            RES_ZERO: fin_res = '0;
            RES_ABS:  fin_res = BLOCK_W'(abs_ent);
            RES_ENT:  fin_res = BLOCK_W'(rd_data_reg);
            default:  fin_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            count_reg  <= COUNT_RESET;
            ptr_reg    <= '0;
            steps_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == REG_SERVICE_OFFSET))
                offset_reg <= OFFSET_W'(cfg_wdata);
            if (cfg_wr_en && (cfg_index == REG_DATA_BLOCK_COUNT))
                count_reg <= cfg_wdata[COUNT_W-1:0];
            ptr_reg   <= ptr_next;
            steps_reg <= steps_next;
        end
    end

    // table port: one write, one read at the pointer's next value
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[ptr_next[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            blk_reg <= req_payload.block;
            idx_reg <= req_payload.index;
            val_reg <= req_payload.value;
        end
        if (cmd.tgt_load)
            tgt_reg <= blk_idx[IW-1:0];
        if (cmd.fin_load)
        begin
            fin_res_reg    <= fin_res;
            fin_status_reg <= cmd.fin_status;
        end
        if (cmd.out_load)
        begin
            out_block_reg  <= fin_res_reg;
            out_status_reg <= fin_status_reg;
        end
    end

    assign rsp_payload.block_out = out_block_reg;
    assign rsp_payload.status    = out_status_reg;

endmodule

// File: rtl/block_chain_table_engine_core.sv
// Block chain table engine: top level joining the sequencer and the datapath.
//
// Keeps a FAT-style chain table of TABLE_DEPTH entries in one single-port-write,
// single-port-read memory and runs one operation per request transfer, giving
// one response transfer. After reset the table is swept to zero, during which
// no request is taken; configuration writes are taken at any time but must
// only be issued while the engine is idle.
// Read and write of an entry pass through a decode state and one read or
// write state; allocate, append, free chain and find last step through the
// table one entry per cycle on its read port in the first-free search or the
// chain walk, and append adds a link write once a free entry is found.
// One request is in progress at a time; a finished response waits in an
// output register while the next request is taken.
module block_chain_table_engine_core
    import bcte_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bcte_req_if.sink              req,
    bcte_rsp_if.source            rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bcte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.payload.op),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    bcte_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req_payload (req.payload),
        .rsp_payload (rsp.payload),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
